// File: rtl/lcgx_pkg.sv
package lcgx_pkg;

    // Widths of the fields and registers
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DW_CNT_W  = POS_W - 2;

    // Function codes of an input word
    localparam logic FUNC_READ = 1'b0;
    localparam logic FUNC_SEEK = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PAST_END = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SEEK_REJ = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MULT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ADD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_KEY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_SZ  = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_ACC_A,
        S_ACC_M,
        S_POW_A,
        S_POW_M,
        S_FINAL
    } t_state;

endpackage

// File: rtl/lcgx_in_if.sv
interface lcgx_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [lcgx_pkg::BYTE_W-1:0]   data_in;
    logic [lcgx_pkg::POS_W-1:0]    seek_target;

    modport source (output valid, output func, output data_in, output seek_target,
                    input ready);
    modport sink   (input valid, input func, input data_in, input seek_target,
                    output ready);
endinterface

// File: rtl/lcgx_out_if.sv
interface lcgx_out_if;
    logic                          valid;
    logic                          ready;
    logic [lcgx_pkg::BYTE_W-1:0]   data_out;
    logic [lcgx_pkg::STAT_W-1:0]   status;
    logic [lcgx_pkg::POS_W-1:0]    position;

    modport source (output valid, output data_out, output status, output position,
                    input ready);
    modport sink   (input valid, input data_out, input status, input position,
                    output ready);
endinterface

// File: rtl/lcgx_cfg_if.sv
interface lcgx_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lcgx_pkg::CFG_IDX_W-1:0]  index;
    logic [lcgx_pkg::KEY_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lcg_keystream_xor_decrypt_core.sv
// Channel | Dir | Payload                           | Word accepted when
// i_in    | in  | func, data_in, seek_target        | i_in.valid && i_in.ready
// o_res   | out | data_out, status, position        | o_res.valid && o_res.ready
// i_cfg   | in  | index (2 bits), data (32 bits)    | i_cfg.valid && i_cfg.ready
//
// A read crossing a dword steps the key once in S_STEP before its result is
// written. A same-dword seek is answered from S_IDLE; else S_ACC_A/S_ACC_M run
// per set bit of the dword distance and S_POW_A/S_POW_M per bit below its top
// set bit, then S_FINAL: one 32x32 multiply-add unit runs the affine key jump.
// Reset (synchronous, active low) clears the registers, key and position.
// A new word enters only when the result register is empty or drains in that
// cycle; a finished multi-cycle word holds until that register is free.
module lcg_keystream_xor_decrypt_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcgx_in_if.sink     i_in,
    lcgx_out_if.source  o_res,
    lcgx_cfg_if.sink    i_cfg
);

    // Shared multiply-add operations
    typedef enum logic [2:0] {
        OP_STEP,
        OP_ACC_A,
        OP_ACC_M,
        OP_POW_A,
        OP_POW_M,
        OP_FINAL
    } t_op;

    lcgx_pkg::t_state r_state, n_state;

    logic [lcgx_pkg::KEY_W-1:0]    r_mult, n_mult;
    logic [lcgx_pkg::KEY_W-1:0]    r_add, n_add;
    logic [lcgx_pkg::KEY_W-1:0]    r_start, n_start;
    logic [lcgx_pkg::POS_W-1:0]    r_size, n_size;
    logic [lcgx_pkg::KEY_W-1:0]    r_key, n_key;
    logic [lcgx_pkg::POS_W-1:0]    r_pos, n_pos;

    logic [lcgx_pkg::KEY_W-1:0]    r_acc_m, n_acc_m;
    logic [lcgx_pkg::KEY_W-1:0]    r_acc_a, n_acc_a;
    logic [lcgx_pkg::KEY_W-1:0]    r_pow_m, n_pow_m;
    logic [lcgx_pkg::KEY_W-1:0]    r_pow_a, n_pow_a;
    logic [lcgx_pkg::DW_CNT_W-1:0] r_n, n_n;
    logic [lcgx_pkg::BYTE_W-1:0]   r_hold_dout, n_hold_dout;

    logic                          r_out_valid, n_out_valid;
    logic [lcgx_pkg::BYTE_W-1:0]   r_out_dout, n_out_dout;
    logic [lcgx_pkg::STAT_W-1:0]   r_out_status, n_out_status;
    logic [lcgx_pkg::POS_W-1:0]    r_out_pos, n_out_pos;

    logic                          w_slot_free;
    logic                          w_in_acc;
    logic                          w_cfg_acc;
    logic                          w_past_end;
    logic [lcgx_pkg::POS_W-1:0]    w_pos_inc;
    logic [lcgx_pkg::BYTE_W-1:0]   w_key_byte;
    logic                          w_seek_rej;
    logic                          w_seek_back;
    logic [lcgx_pkg::POS_W-1:0]    w_base_pos;
    logic [lcgx_pkg::KEY_W-1:0]    w_base_key;
    logic [lcgx_pkg::DW_CNT_W-1:0] w_jump_n;
    logic [lcgx_pkg::DW_CNT_W-1:0] w_n_shift;

    t_op                           w_op;
    logic [lcgx_pkg::KEY_W-1:0]    w_mul_a, w_mul_b, w_add_c;
    logic [lcgx_pkg::KEY_W-1:0]    w_prod, w_mac;

    // Handshakes
    assign w_slot_free = !r_out_valid || o_res.ready;
    assign i_in.ready  = (r_state == lcgx_pkg::S_IDLE) && w_slot_free;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid;

    assign o_res.valid    = r_out_valid;
    assign o_res.data_out = r_out_dout;
    assign o_res.status   = r_out_status;
    assign o_res.position = r_out_pos;

    // Decode the incoming word
    assign w_past_end  = r_pos >= r_size;
    assign w_pos_inc   = r_pos + 32'd1;
    assign w_key_byte  = r_key[{r_pos[1:0], 3'b000} +: lcgx_pkg::BYTE_W];
    assign w_seek_rej  = i_in.seek_target >= r_size;
    assign w_seek_back = i_in.seek_target < r_pos;
    assign w_base_pos  = w_seek_back ? '0 : r_pos;
    assign w_base_key  = w_seek_back ? r_start : r_key;
    assign w_jump_n    = i_in.seek_target[lcgx_pkg::POS_W-1:2] -
                         w_base_pos[lcgx_pkg::POS_W-1:2];
    assign w_n_shift   = r_n >> 1;

    // Select the operation of the shared unit
    always_comb begin
        unique case (r_state)
            lcgx_pkg::S_STEP:  w_op = OP_STEP;
            lcgx_pkg::S_ACC_A: w_op = OP_ACC_A;
            lcgx_pkg::S_ACC_M: w_op = OP_ACC_M;
            lcgx_pkg::S_POW_A: w_op = OP_POW_A;
            lcgx_pkg::S_POW_M: w_op = OP_POW_M;
            default:           w_op = OP_FINAL;
        endcase
    end

    always_comb begin
        unique case (w_op)
            OP_STEP:  begin w_mul_a = r_key;   w_mul_b = r_mult;  w_add_c = r_add;   end
            OP_ACC_A: begin w_mul_a = r_pow_m; w_mul_b = r_acc_a; w_add_c = r_pow_a; end
            OP_ACC_M: begin w_mul_a = r_pow_m; w_mul_b = r_acc_m; w_add_c = '0;      end
            OP_POW_A: begin w_mul_a = r_pow_m; w_mul_b = r_pow_a; w_add_c = r_pow_a; end
            OP_POW_M: begin w_mul_a = r_pow_m; w_mul_b = r_pow_m; w_add_c = '0;      end
            default:  begin w_mul_a = r_acc_m; w_mul_b = r_key;   w_add_c = r_acc_a; end
        endcase
    end

    // Multiply-add modulo 2^32
    assign w_prod = w_mul_a * w_mul_b;
    assign w_mac  = w_prod + w_add_c;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            lcgx_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.func == lcgx_pkg::FUNC_READ) begin
                        if (!w_past_end && (w_pos_inc[1:0] == 2'd0)) begin
                            n_state = lcgx_pkg::S_STEP;
                        end
                    end else if (!w_seek_rej && (i_in.seek_target != r_pos) &&
                                 (w_jump_n != '0)) begin
                        n_state = w_jump_n[0] ? lcgx_pkg::S_ACC_A : lcgx_pkg::S_POW_A;
                    end
                end
            end
            lcgx_pkg::S_STEP, lcgx_pkg::S_FINAL: begin
                if (w_slot_free) begin
                    n_state = lcgx_pkg::S_IDLE;
                end
            end
            lcgx_pkg::S_ACC_A: n_state = lcgx_pkg::S_ACC_M;
            lcgx_pkg::S_ACC_M: begin
                n_state = (w_n_shift == '0) ? lcgx_pkg::S_FINAL : lcgx_pkg::S_POW_A;
            end
            lcgx_pkg::S_POW_A: n_state = lcgx_pkg::S_POW_M;
            lcgx_pkg::S_POW_M: begin
                if (w_n_shift == '0) begin
                    n_state = lcgx_pkg::S_FINAL;
                end else begin
                    n_state = w_n_shift[0] ? lcgx_pkg::S_ACC_A : lcgx_pkg::S_POW_A;
                end
            end
            default: n_state = lcgx_pkg::S_IDLE;
        endcase
    end

    // Datapath and result register
    always_comb begin
        n_mult       = r_mult;
        n_add        = r_add;
        n_start      = r_start;
        n_size       = r_size;
        n_key        = r_key;
        n_pos        = r_pos;
        n_acc_m      = r_acc_m;
        n_acc_a      = r_acc_a;
        n_pow_m      = r_pow_m;
        n_pow_a      = r_pow_a;
        n_n          = r_n;
        n_hold_dout  = r_hold_dout;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_dout   = r_out_dout;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;

        unique case (r_state) inside
            lcgx_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.func == lcgx_pkg::FUNC_READ) begin
                        if (w_past_end) begin
                            n_out_valid  = 1'b1;
                            n_out_dout   = '0;
                            n_out_status = lcgx_pkg::STAT_PAST_END;
                            n_out_pos    = r_pos;
                        end else begin
                            n_pos       = w_pos_inc;
                            n_hold_dout = i_in.data_in ^ w_key_byte;
                            // emit now unless the key must step first
                            if (w_pos_inc[1:0] != 2'd0) begin
                                n_out_valid  = 1'b1;
                                n_out_dout   = i_in.data_in ^ w_key_byte;
                                n_out_status = lcgx_pkg::STAT_OK;
                                n_out_pos    = w_pos_inc;
                            end
                        end
                    end else if (w_seek_rej) begin
                        n_out_valid  = 1'b1;
                        n_out_dout   = '0;
                        n_out_status = lcgx_pkg::STAT_SEEK_REJ;
                        n_out_pos    = r_pos;
                    end else if (i_in.seek_target == r_pos) begin
                        n_out_valid  = 1'b1;
                        n_out_dout   = '0;
                        n_out_status = lcgx_pkg::STAT_OK;
                        n_out_pos    = r_pos;
                    end else begin
                        n_pos       = i_in.seek_target;
                        n_key       = w_base_key;
                        n_hold_dout = '0;
                        n_n         = w_jump_n;
                        n_acc_m     = 32'd1;
                        n_acc_a     = '0;
                        n_pow_m     = r_mult;
                        n_pow_a     = r_add;
                        // same dword: no key step needed
                        if (w_jump_n == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_dout   = '0;
                            n_out_status = lcgx_pkg::STAT_OK;
                            n_out_pos    = i_in.seek_target;
                        end
                    end
                end
            end
            lcgx_pkg::S_STEP, lcgx_pkg::S_FINAL: begin
                if (w_slot_free) begin
                    n_key        = w_mac;
                    n_out_valid  = 1'b1;
                    n_out_dout   = r_hold_dout;
                    n_out_status = lcgx_pkg::STAT_OK;
                    n_out_pos    = r_pos;
                end
            end
            lcgx_pkg::S_ACC_A: n_acc_a = w_mac;
            lcgx_pkg::S_ACC_M: n_acc_m = w_mac;
            lcgx_pkg::S_POW_A: n_pow_a = w_mac;
            lcgx_pkg::S_POW_M: begin
                n_pow_m = w_mac;
                n_n     = w_n_shift;
            end
            default: ;
        endcase

        // Register writes
        if (w_cfg_acc) begin
            unique case (i_cfg.index)
                lcgx_pkg::REG_KEY_MULT: n_mult = i_cfg.data;
                lcgx_pkg::REG_KEY_ADD:  n_add  = i_cfg.data;
                lcgx_pkg::REG_START_KEY: begin
                    n_start = i_cfg.data;
                    n_key   = i_cfg.data;
                    n_pos   = '0;
                end
                lcgx_pkg::REG_ENTRY_SZ: n_size = i_cfg.data;
                default: ;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcgx_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_mult      <= '0;
            r_add       <= '0;
            r_start     <= '0;
            r_size      <= '0;
            r_key       <= '0;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mult      <= n_mult;
            r_add       <= n_add;
            r_start     <= n_start;
            r_size      <= n_size;
            r_key       <= n_key;
            r_pos       <= n_pos;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_acc_m      <= n_acc_m;
        r_acc_a      <= n_acc_a;
        r_pow_m      <= n_pow_m;
        r_pow_a      <= n_pow_a;
        r_n          <= n_n;
        r_hold_dout  <= n_hold_dout;
        r_out_dout   <= n_out_dout;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    // A read past the end yields a past-end word next cycle
    a_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.func == lcgx_pkg::FUNC_READ) && w_past_end)
        |=> (r_out_valid && (r_out_status == lcgx_pkg::STAT_PAST_END)))
        else $error("read past end not flagged");

    // A rejected seek leaves the position alone
    a_seek_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.func == lcgx_pkg::FUNC_SEEK) && w_seek_rej && !w_cfg_acc)
        |=> (r_pos == $past(r_pos)))
        else $error("rejected seek moved position");

    // The accumulate step only runs for a set bit of the jump count
    a_acc_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcgx_pkg::S_ACC_A) |-> r_n[0])
        else $error("accumulate step on a clear bit");

    // The jump loop never runs on an empty count
    a_jump_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lcgx_pkg::S_POW_A) || (r_state == lcgx_pkg::S_ACC_M))
        |-> (r_n != '0))
        else $error("jump loop with zero count");

endmodule
